// ----- hdl/erlog_pkg.sv -----
// shared types, sizes, store/live mask tables and position helpers
// for the event ring log; used by every file in hdl, depends on nothing
package erlog_pkg;

  localparam int DEPTH    = 8192;
  localparam int SESSIONS = 8;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int SW       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  typedef logic [AW-1:0] pos_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [SW-1:0] sid_t;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_RESUME = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_END    = 3'd4;

  localparam logic [3:0] TYPE_ANY = 4'hF;

  typedef struct packed {
    logic [31:0] ev_time;
    logic [7:0]  ev_state;
    logic [4:0]  ev_subtype;
    logic [3:0]  ev_type;
  } log_entry_t;

  typedef struct packed {
    logic [3:0]  filter;
    logic [31:0] t_start;
    logic [31:0] t_end;
    pos_t        pos;
    cnt_t        rem;
  } sess_t;

  localparam sess_t SESS_RESET = '{filter: TYPE_ANY, default: '0};

  typedef struct packed {
    logic en;
    sid_t addr;
  } sess_rd_req_t;

  typedef struct packed {
    logic  en;
    sid_t  addr;
    sess_t data;
  } sess_wr_req_t;

  typedef struct packed {
    logic en;
    pos_t addr;
  } log_rd_req_t;

  typedef struct packed {
    logic       en;
    pos_t       addr;
    log_entry_t data;
  } log_wr_req_t;

  // per-type subtype masks: which subtypes go to the log
  function automatic logic [31:0] store_mask(input logic [3:0] etype);
    logic [31:0] m;
    unique case (etype)
      4'd1:    m = 32'h1F73FFFE;
      4'd2:    m = 32'h00000002;
      4'd3:    m = 32'h00000002;
      4'd4:    m = 32'h00030FFA;
      4'd5:    m = 32'h0000003E;
      4'd6:    m = 32'h00001FFE;
      4'd7:    m = 32'h00000462;
      4'd8:    m = 32'h0000027E;
      4'd9:    m = 32'h00000002;
      default: m = 32'h00000000;
    endcase
    return m;
  endfunction

  // per-type subtype masks: which subtypes are sent live
  function automatic logic [31:0] live_mask(input logic [3:0] etype);
    logic [31:0] m;
    unique case (etype)
      4'd1:    m = 32'h117FFFFE;
      4'd2:    m = 32'h00000002;
      4'd3:    m = 32'h00000002;
      4'd4:    m = 32'h0003FBF8;
      4'd5:    m = 32'h0000002A;
      4'd6:    m = 32'h000000F2;
      4'd7:    m = 32'h00003FFE;
      4'd8:    m = 32'h0000019C;
      4'd9:    m = 32'h00000006;
      default: m = 32'h00000000;
    endcase
    return m;
  endfunction

  function automatic pos_t pos_inc(input pos_t p);
    return (p == pos_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic pos_t pos_dec(input pos_t p);
    return (p == '0) ? pos_t'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ----- hdl/erlog_log_ram.sv -----
// event log memory: one write port, one registered read port
// depends on erlog_pkg for entry and request types
module erlog_log_ram (
  input  logic                   clk,
  input  erlog_pkg::log_wr_req_t wr,
  input  erlog_pkg::log_rd_req_t rd,
  output erlog_pkg::log_entry_t  rd_data
);

  erlog_pkg::log_entry_t mem [erlog_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- hdl/erlog_sess_table.sv -----
// search session table: small synchronous memory plus per-entry valid bits
// an entry never written reads as the reset session; depends on erlog_pkg
module erlog_sess_table (
  input  logic                    clk,
  input  logic                    rst,
  input  erlog_pkg::sess_rd_req_t rd,
  input  erlog_pkg::sess_wr_req_t wr,
  output erlog_pkg::sess_t        rd_data
);

  erlog_pkg::sess_t                  mem [erlog_pkg::SESSIONS];
  logic [erlog_pkg::SESSIONS-1:0]    vld;
  erlog_pkg::sess_t                  rd_q;
  logic                              rd_vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q     <= mem[rd.addr];
      rd_vld_q <= vld[rd.addr];
    end
  end

  assign rd_data = rd_vld_q ? rd_q : erlog_pkg::SESS_RESET;

endmodule

// ----- hdl/event_ring_log_with_filtered_search_unit.sv -----
// event ring log with filtered newest-first search sessions, top level
// depends on erlog_pkg, erlog_log_ram and erlog_sess_table
// one item at a time; an unstored write, session start/resume/end, unknown command or
// bad session goes straight to S_OUT; a stored write first walks the session table one
// entry a cycle in S_WALK to fix positions and counts; a read-next reads its session in
// S_RDSESS, then scans the log newest first in S_SCAN (one log read a cycle) until a hit
// or the entries run dry, and an empty session is reported without any log read
// input is taken again as soon as the result sits in the output register
// sync reset: write position 0, no wrap, all sessions free with reset filters; no log clear
module event_ring_log_with_filtered_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [2:0]  session,
  input  logic [3:0]  event_type,
  input  logic [4:0]  event_subtype,
  input  logic [7:0]  event_state,
  input  logic [31:0] event_time,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        stored,
  output logic        live,
  output logic [3:0]  found_type,
  output logic [4:0]  found_subtype,
  output logic [7:0]  found_state,
  output logic [31:0] found_time
);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_RDSESS, S_SCAN, S_OUT} state_t;

  localparam logic [erlog_pkg::SW:0] WALK_END = (erlog_pkg::SW + 1)'(erlog_pkg::SESSIONS);

  state_t                         state;
  erlog_pkg::pos_t                wpos;
  logic                           wrapped;
  logic [erlog_pkg::SESSIONS-1:0] busy;

  // write walk over the session table
  erlog_pkg::pos_t                old_pos;
  logic                           old_wrap;
  logic [erlog_pkg::SW:0]         walk_idx;
  logic                           wp_vld;
  erlog_pkg::sid_t                wp_idx;

  // read-next scan
  erlog_pkg::sid_t                ses_r;
  logic [3:0]                     sc_filter;
  logic [31:0]                    sc_start;
  logic [31:0]                    sc_end;
  erlog_pkg::pos_t                rd_pos;
  erlog_pkg::cnt_t                rd_left;
  logic                           lp_vld;
  erlog_pkg::pos_t                lp_pos;
  erlog_pkg::cnt_t                lp_rem;

  // pending result, moved to the output register in S_OUT
  logic                           res_status;
  logic                           res_stored;
  logic                           res_live;
  logic [3:0]                     res_ftype;
  logic [4:0]                     res_fsub;
  logic [7:0]                     res_fstate;
  logic [31:0]                    res_ftime;

  logic                           acc;
  logic                           ses_ok;
  erlog_pkg::sid_t                sid_in;
  logic [31:0]                    st_mask;
  logic [31:0]                    lv_mask;
  logic                           st_bit;
  logic                           lv_bit;
  logic                           found;
  logic                           walk_issue;

  erlog_pkg::log_wr_req_t         log_wr;
  erlog_pkg::log_rd_req_t         log_rd;
  erlog_pkg::log_entry_t          log_q;
  erlog_pkg::sess_rd_req_t        sess_rd;
  erlog_pkg::sess_wr_req_t        sess_wr;
  erlog_pkg::sess_t               sess_q;
  erlog_pkg::sess_t               walk_wb;

  assign in_ready   = (state == S_IDLE);
  assign acc        = in_valid && in_ready;
  assign ses_ok     = int'(session) < erlog_pkg::SESSIONS;
  assign sid_in     = erlog_pkg::sid_t'(session);
  assign st_mask    = erlog_pkg::store_mask(event_type);
  assign lv_mask    = erlog_pkg::live_mask(event_type);
  assign st_bit     = st_mask[event_subtype];
  assign lv_bit     = lv_mask[event_subtype];
  assign walk_issue = (state == S_WALK) && (walk_idx < WALK_END);

  // entry in the read pipe passes type and time window
  assign found = (state == S_SCAN) && lp_vld &&
                 ((sc_filter == erlog_pkg::TYPE_ANY) || (sc_filter == log_q.ev_type)) &&
                 ((sc_start == '0) || (log_q.ev_time >= sc_start)) &&
                 ((sc_end == '0) || (log_q.ev_time <= sc_end));

  // a busy session either slides forward past an overwritten entry or gains one entry
  always_comb begin
    walk_wb = sess_q;
    if (old_wrap && (sess_q.pos == old_pos)) begin
      walk_wb.pos = erlog_pkg::pos_inc(sess_q.pos);
    end else if (sess_q.rem < erlog_pkg::cnt_t'(erlog_pkg::DEPTH)) begin
      walk_wb.rem = sess_q.rem + 1'b1;
    end
  end

  // log memory ports
  always_comb begin
    log_wr.en   = acc && (cmd == erlog_pkg::CMD_WRITE) && st_bit;
    log_wr.addr = wpos;
    log_wr.data = '{ev_time: event_time, ev_state: event_state,
                    ev_subtype: event_subtype, ev_type: event_type};
    log_rd.en   = (state == S_SCAN) && !found && (rd_left != '0);
    log_rd.addr = rd_pos;
  end

  // session table ports
  always_comb begin
    sess_rd.en   = (acc && (cmd == erlog_pkg::CMD_READ) && ses_ok) || walk_issue;
    sess_rd.addr = (state == S_WALK) ? walk_idx[erlog_pkg::SW-1:0] : sid_in;

    sess_wr.en   = 1'b0;
    sess_wr.addr = sid_in;
    sess_wr.data = walk_wb;
    priority if (acc && (cmd == erlog_pkg::CMD_START) && ses_ok) begin
      sess_wr.en           = 1'b1;
      sess_wr.data.filter  = event_type;
      sess_wr.data.t_start = start_time;
      sess_wr.data.t_end   = end_time;
      sess_wr.data.pos     = erlog_pkg::pos_dec(wpos);
      sess_wr.data.rem     = wrapped ? erlog_pkg::cnt_t'(erlog_pkg::DEPTH)
                                     : erlog_pkg::cnt_t'(wpos);
    end else if ((state == S_WALK) && wp_vld && busy[wp_idx]) begin
      sess_wr.en   = 1'b1;
      sess_wr.addr = wp_idx;
    end else if (found) begin
      // stop just past the hit, keep what is left for the next read
      sess_wr.en   = 1'b1;
      sess_wr.addr = ses_r;
      sess_wr.data = '{filter: sc_filter, t_start: sc_start, t_end: sc_end,
                       pos: erlog_pkg::pos_dec(lp_pos), rem: lp_rem};
    end else if ((state == S_SCAN) && !lp_vld && (rd_left == '0)) begin
      // walked everything without a hit
      sess_wr.en   = 1'b1;
      sess_wr.addr = ses_r;
      sess_wr.data = '{filter: sc_filter, t_start: sc_start, t_end: sc_end,
                       pos: rd_pos, rem: '0};
    end else begin
      sess_wr.en = 1'b0;
    end
  end

  erlog_log_ram u_log (
    .clk     (clk),
    .wr      (log_wr),
    .rd      (log_rd),
    .rd_data (log_q)
  );

  erlog_sess_table u_sess (
    .clk     (clk),
    .rst     (rst),
    .rd      (sess_rd),
    .wr      (sess_wr),
    .rd_data (sess_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wpos      <= '0;
      wrapped   <= 1'b0;
      busy      <= '0;
      walk_idx  <= '0;
      wp_vld    <= 1'b0;
      lp_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_OUT owns out_valid while it loads the output register
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            // status 1 only for a bad session; read-next fills in the rest later
            res_status <= (cmd != erlog_pkg::CMD_WRITE) && (cmd <= erlog_pkg::CMD_END) &&
                          !ses_ok;
            res_stored <= (cmd == erlog_pkg::CMD_WRITE) && st_bit;
            res_live   <= (cmd == erlog_pkg::CMD_WRITE) && lv_bit;
            res_ftype  <= '0;
            res_fsub   <= '0;
            res_fstate <= '0;
            res_ftime  <= '0;
            priority if (cmd == erlog_pkg::CMD_WRITE) begin
              if (st_bit) begin
                old_pos  <= wpos;
                old_wrap <= wrapped;
                wpos     <= erlog_pkg::pos_inc(wpos);
                if (wpos == erlog_pkg::pos_t'(erlog_pkg::DEPTH - 1)) begin
                  wrapped <= 1'b1;
                end
                walk_idx <= '0;
                wp_vld   <= 1'b0;
                state    <= S_WALK;
              end else begin
                state <= S_OUT;
              end
            end else if (cmd > erlog_pkg::CMD_END) begin
              state <= S_OUT;
            end else if (!ses_ok) begin
              state <= S_OUT;
            end else if (cmd == erlog_pkg::CMD_READ) begin
              ses_r <= sid_in;
              state <= S_RDSESS;
            end else if (cmd == erlog_pkg::CMD_END) begin
              busy[sid_in] <= 1'b0;
              state        <= S_OUT;
            end else begin
              // start or resume
              busy[sid_in] <= 1'b1;
              state        <= S_OUT;
            end
          end
        end
        S_WALK: begin
          // read one session entry a cycle, write back the previous one
          if (walk_issue) begin
            walk_idx <= walk_idx + 1'b1;
            wp_vld   <= 1'b1;
            wp_idx   <= walk_idx[erlog_pkg::SW-1:0];
          end else begin
            wp_vld <= 1'b0;
            if (!wp_vld) begin
              state <= S_OUT;
            end
          end
        end
        S_RDSESS: begin
          sc_filter <= sess_q.filter;
          sc_start  <= sess_q.t_start;
          sc_end    <= sess_q.t_end;
          rd_pos    <= sess_q.pos;
          rd_left   <= sess_q.rem;
          lp_vld    <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          // log reads run one ahead of the filter check; a hit drops the extra read
          if (found) begin
            lp_vld     <= 1'b0;
            res_ftype  <= log_q.ev_type;
            res_fsub   <= log_q.ev_subtype;
            res_fstate <= log_q.ev_state;
            res_ftime  <= log_q.ev_time;
            state      <= S_OUT;
          end else if (rd_left != '0) begin
            lp_vld  <= 1'b1;
            lp_pos  <= rd_pos;
            lp_rem  <= rd_left - 1'b1;
            rd_pos  <= erlog_pkg::pos_dec(rd_pos);
            rd_left <= rd_left - 1'b1;
          end else if (!lp_vld) begin
            res_status <= 1'b1;
            state      <= S_OUT;
          end else begin
            lp_vld <= 1'b0;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            stored        <= res_stored;
            live          <= res_live;
            found_type    <= res_ftype;
            found_subtype <= res_fsub;
            found_state   <= res_fstate;
            found_time    <= res_ftime;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one item in flight: an accepted item closes the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // the session walk never runs past the table
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_idx <= WALK_END)
    else $error("session walk index out of range");

  // a scan never has more entries left than the log holds
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> rd_left <= erlog_pkg::cnt_t'(erlog_pkg::DEPTH))
    else $error("scan count exceeds log depth");

  // once the log has wrapped it stays wrapped until reset
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(wrapped) |-> wrapped)
    else $error("wrap flag cleared without reset");

  // a session table write and a log write never come from the same item step
  a_no_dual_write: assert property (@(posedge clk) disable iff (rst)
    log_wr.en |-> !sess_wr.en)
    else $error("log and session table written together");

endmodule

// ----- verif/tb_event_ring_log_with_filtered_search_unit.sv -----
// self-checking bench for the event ring log with filtered search sessions
// depends on erlog_pkg (sizes, command codes, position and count types) and the top level
`timescale 1ns / 100ps

module tb_event_ring_log_with_filtered_search_unit;

  // spare command codes the block must answer with an all-zero result
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [3:0] TYPE_UNMASKED = 4'd0;
  localparam logic [3:0] TYPE_LAST_MASKED = 4'd9;
  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  // per-type subtype bits, type 15 first down to type 0
  localparam logic [15:0][31:0] KEEP_MASK = {
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0000_0002, 32'h0000_027E, 32'h0000_0462, 32'h0000_1FFE, 32'h0000_003E,
    32'h0003_0FFA, 32'h0000_0002, 32'h0000_0002, 32'h1F73_FFFE, 32'h0
  };
  localparam logic [15:0][31:0] LIVE_MASK = {
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0000_0006, 32'h0000_019C, 32'h0000_3FFE, 32'h0000_00F2, 32'h0000_002A,
    32'h0003_FBF8, 32'h0000_0002, 32'h0000_0002, 32'h117F_FFFE, 32'h0
  };

  // a read-next may walk the whole ring with nothing accepted meanwhile
  localparam int STALL_LIMIT = 4 * (erlog_pkg::DEPTH + erlog_pkg::SESSIONS + 16);
  localparam int DRAIN_CYCLES = 4 * (erlog_pkg::SESSIONS + 8);
  localparam int FILL_ITEMS = 400;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  session;
    logic [3:0]  etype;
    logic [4:0]  esub;
    logic [7:0]  estate;
    logic [31:0] etime;
    logic [31:0] tstart;
    logic [31:0] tend;
  } log_cmd_t;

  typedef struct packed {
    logic        status;
    logic        stored;
    logic        live;
    logic [3:0]  ftype;
    logic [4:0]  fsub;
    logic [7:0]  fstate;
    logic [31:0] ftime;
  } log_reply_t;

  typedef struct packed {
    log_cmd_t   c;
    log_reply_t want;
  } pending_t;

  typedef struct packed {
    logic [3:0]  etype;
    logic [4:0]  esub;
    logic [7:0]  estate;
    logic [31:0] etime;
  } ring_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = '0;
  logic [2:0]  session = '0;
  logic [3:0]  event_type = '0;
  logic [4:0]  event_subtype = '0;
  logic [7:0]  event_state = '0;
  logic [31:0] event_time = '0;
  logic [31:0] start_time = '0;
  logic [31:0] end_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic        stored;
  logic        live;
  logic [3:0]  found_type;
  logic [4:0]  found_subtype;
  logic [7:0]  found_state;
  logic [31:0] found_time;

  event_ring_log_with_filtered_search_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .session(session), .event_type(event_type),
    .event_subtype(event_subtype), .event_state(event_state),
    .event_time(event_time), .start_time(start_time), .end_time(end_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .stored(stored), .live(live),
    .found_type(found_type), .found_subtype(found_subtype),
    .found_state(found_state), .found_time(found_time)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the log and the search sessions
  ring_entry_t     shadow_log [erlog_pkg::DEPTH];
  bit              written_map [erlog_pkg::DEPTH];
  erlog_pkg::pos_t wr_pos;
  bit              ring_full;
  bit              sess_busy [erlog_pkg::SESSIONS];
  logic [3:0]      sess_filter [erlog_pkg::SESSIONS];
  logic [31:0]     sess_lo [erlog_pkg::SESSIONS];
  logic [31:0]     sess_hi [erlog_pkg::SESSIONS];
  erlog_pkg::pos_t sess_pos [erlog_pkg::SESSIONS];
  erlog_pkg::cnt_t sess_left [erlog_pkg::SESSIONS];

  pending_t   pending_q [$];
  log_reply_t reply_q [$];
  log_reply_t in_flight_want;

  int walk_budget = 250000;
  int accepted_n = 0;
  int results_n = 0;
  int third_mark = 1 << 30;
  int mismatches = 0;
  int idle_cycles = 0;
  int kept_n = 0;
  int live_n = 0;
  int found_n = 0;
  int empty_n = 0;

  // walk a session backward, newest first, until an entry passes its filters;
  // returns 0 if the walk would touch an entry that was never written
  function automatic bit walk_session(input int s, input bit commit,
                                      output log_reply_t r, output int steps);
    erlog_pkg::pos_t p;
    erlog_pkg::cnt_t left;
    ring_entry_t     e;
    bit              hit;
    bit              clean;
    p = sess_pos[s];
    left = sess_left[s];
    r = '0;
    hit = 1'b0;
    clean = 1'b1;
    steps = 0;
    while (left > 0 && !hit) begin
      if (!written_map[p]) clean = 1'b0;
      e = shadow_log[p];
      left = left - 1'b1;
      steps++;
      hit = (sess_filter[s] == erlog_pkg::TYPE_ANY || sess_filter[s] == e.etype) &&
            (sess_lo[s] == '0 || e.etime >= sess_lo[s]) &&
            (sess_hi[s] == '0 || e.etime <= sess_hi[s]);
      p = (p == '0) ? erlog_pkg::pos_t'(erlog_pkg::DEPTH - 1) : p - 1'b1;
      if (hit) begin
        r.ftype = e.etype;
        r.fsub = e.esub;
        r.fstate = e.estate;
        r.ftime = e.etime;
      end
    end
    r.status = !hit;
    if (commit) begin
      sess_pos[s] = p;
      sess_left[s] = left;
    end
    return clean;
  endfunction

  // expected result of one item, advancing the shadow state
  function automatic log_reply_t predict_log_cmd(input log_cmd_t c);
    log_reply_t      r;
    erlog_pkg::pos_t old_pos;
    bit              old_full;
    int              steps;
    r = '0;
    if (c.cmd == erlog_pkg::CMD_WRITE) begin
      r.stored = KEEP_MASK[c.etype][c.esub];
      r.live = LIVE_MASK[c.etype][c.esub];
      if (r.stored) begin
        old_pos = wr_pos;
        old_full = ring_full;
        shadow_log[old_pos] = '{etype: c.etype, esub: c.esub, estate: c.estate,
                                etime: c.etime};
        written_map[old_pos] = 1'b1;
        if (old_pos == erlog_pkg::pos_t'(erlog_pkg::DEPTH - 1)) begin
          wr_pos = '0;
          ring_full = 1'b1;
        end else begin
          wr_pos = old_pos + 1'b1;
        end
        // busy sessions either slide off the overwritten entry or gain one to read
        for (int s = 0; s < erlog_pkg::SESSIONS; s++) begin
          if (sess_busy[s]) begin
            if (old_full && sess_pos[s] == old_pos)
              sess_pos[s] = (sess_pos[s] == erlog_pkg::pos_t'(erlog_pkg::DEPTH - 1)) ?
                            '0 : sess_pos[s] + 1'b1;
            else if (sess_left[s] < erlog_pkg::cnt_t'(erlog_pkg::DEPTH))
              sess_left[s] = sess_left[s] + 1'b1;
          end
        end
      end
    end else if (c.cmd > erlog_pkg::CMD_END) begin
      // spare codes leave everything alone
    end else if (int'(c.session) >= erlog_pkg::SESSIONS) begin
      r.status = 1'b1;
    end else if (c.cmd == erlog_pkg::CMD_START) begin
      sess_busy[c.session] = 1'b1;
      sess_filter[c.session] = c.etype;
      sess_lo[c.session] = c.tstart;
      sess_hi[c.session] = c.tend;
      sess_left[c.session] = ring_full ? erlog_pkg::cnt_t'(erlog_pkg::DEPTH)
                                       : erlog_pkg::cnt_t'(wr_pos);
      sess_pos[c.session] = (wr_pos == '0) ? erlog_pkg::pos_t'(erlog_pkg::DEPTH - 1)
                                           : wr_pos - 1'b1;
    end else if (c.cmd == erlog_pkg::CMD_RESUME) begin
      sess_busy[c.session] = 1'b1;
    end else if (c.cmd == erlog_pkg::CMD_END) begin
      sess_busy[c.session] = 1'b0;
    end else begin
      void'(walk_session(int'(c.session), 1'b1, r, steps));
    end
    return r;
  endfunction

  // queue one item with its expectation; a read that would reach a never
  // written entry becomes a fresh start, one that walks too far becomes an end
  task automatic queue_cmd(input log_cmd_t c);
    pending_t   p;
    log_reply_t dry;
    int         steps;
    if (c.cmd == erlog_pkg::CMD_READ && int'(c.session) < erlog_pkg::SESSIONS) begin
      if (!walk_session(int'(c.session), 1'b0, dry, steps))
        c.cmd = erlog_pkg::CMD_START;
      else if (steps > walk_budget)
        c.cmd = erlog_pkg::CMD_END;
      else
        walk_budget -= steps;
    end
    p.c = c;
    p.want = predict_log_cmd(c);
    pending_q.push_back(p);
    if (c.cmd == erlog_pkg::CMD_WRITE) begin
      kept_n += int'(p.want.stored);
      live_n += int'(p.want.live);
    end else if (c.cmd == erlog_pkg::CMD_READ) begin
      if (p.want.status) empty_n++;
      else found_n++;
    end
  endtask

  function automatic log_cmd_t mk(input logic [2:0] op, input logic [2:0] sid,
                                  input logic [3:0] ty, input logic [4:0] sub,
                                  input logic [7:0] st, input logic [31:0] stamp,
                                  input logic [31:0] lo, input logic [31:0] hi);
    log_cmd_t c;
    c = '{cmd: op, session: sid, etype: ty, esub: sub, estate: st, etime: stamp,
          tstart: lo, tend: hi};
    return c;
  endfunction

  // times cluster in a narrow band so search windows actually catch events
  function automatic logic [31:0] rand_stamp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return STAMP_MAX;
    if (r < 4) return $urandom;
    return $urandom_range(1, 4000);
  endfunction

  function automatic log_cmd_t noise_cmd();
    log_cmd_t c;
    c.cmd = 3'($urandom_range(0, 7));
    c.session = 3'($urandom_range(0, 7));
    c.etype = 4'($urandom_range(0, 15));
    c.esub = 5'($urandom_range(0, 31));
    c.estate = 8'($urandom_range(0, 255));
    c.etime = $urandom;
    c.tstart = $urandom;
    c.tend = $urandom;
    return c;
  endfunction

  // mostly well-formed session traffic over a few sessions, some noise
  task automatic random_phase(input int n);
    log_cmd_t c;
    int       roll;
    repeat (n) begin
      c = noise_cmd();
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) c.session = 3'($urandom_range(0, 3));
      if (roll < 38) begin
        c.cmd = erlog_pkg::CMD_WRITE;
        if ($urandom_range(0, 99) < 85) c.etype = 4'($urandom_range(1, TYPE_LAST_MASKED));
        c.etime = rand_stamp();
      end else if (roll < 50) begin
        c.cmd = erlog_pkg::CMD_START;
        if ($urandom_range(0, 1)) c.etype = erlog_pkg::TYPE_ANY;
        c.tstart = $urandom_range(0, 1) ? '0 : rand_stamp();
        c.tend = $urandom_range(0, 1) ? '0 : rand_stamp();
      end else if (roll < 80) begin
        c.cmd = erlog_pkg::CMD_READ;
      end else if (roll < 86) begin
        c.cmd = erlog_pkg::CMD_RESUME;
      end else if (roll < 92) begin
        c.cmd = erlog_pkg::CMD_END;
      end else if (roll < 96) begin
        c.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      queue_cmd(c);
    end
  endtask

  function automatic int sender_idle_pct();
    if (accepted_n < third_mark) return 25;
    if (accepted_n < 2 * third_mark) return 53;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (results_n < third_mark) return 53;
    if (results_n < 2 * third_mark) return 25;
    return 0;
  endfunction

  task automatic note_mismatch(input log_reply_t want, input log_reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d: expected st=%0d kept=%0d live=%0d ty=%0d sub=%0d state=%0d t=%0d, got st=%0d kept=%0d live=%0d ty=%0d sub=%0d state=%0d t=%0d",
               results_n, want.status, want.stored, want.live, want.ftype, want.fsub,
               want.fstate, want.ftime, got.status, got.stored, got.live, got.ftype,
               got.fsub, got.fstate, got.ftime);
  endtask

  // driver: present the next item once the current one is taken
  always @(posedge clk) begin : feed
    pending_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(in_flight_want);
        accepted_n++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt = pending_q.pop_front();
          in_flight_want = nxt.want;
          cmd <= nxt.c.cmd;
          session <= nxt.c.session;
          event_type <= nxt.c.etype;
          event_subtype <= nxt.c.esub;
          event_state <= nxt.c.estate;
          event_time <= nxt.c.etime;
          start_time <= nxt.c.tstart;
          end_time <= nxt.c.tend;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin : observe
    log_reply_t got;
    log_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status: status, stored: stored, live: live, ftype: found_type,
                fsub: found_subtype, fstate: found_state, ftime: found_time};
        if (reply_q.size() == 0) begin
          want = '0;
          if (mismatches < 10) $display("result %0d arrived with nothing expected", results_n);
          note_mismatch(want, got);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) note_mismatch(want, got);
        end
        results_n++;
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // watchdog on cycles where neither side moves
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results still due", idle_cycles,
               reply_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run
    log_cmd_t c;
    wr_pos = '0;
    ring_full = 1'b0;
    for (int s = 0; s < erlog_pkg::SESSIONS; s++) begin
      sess_busy[s] = 1'b0;
      sess_filter[s] = erlog_pkg::TYPE_ANY;
      sess_lo[s] = '0;
      sess_hi[s] = '0;
      sess_pos[s] = '0;
      sess_left[s] = '0;
    end

    // directed: empty log, start at write position zero, mask corners
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd0, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd0, erlog_pkg::TYPE_ANY, 5'd31, 8'hFF, STAMP_MAX,
                 '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd0, 4'd0, 5'd0, 8'd0, '0, STAMP_MAX, STAMP_MAX));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd7, TYPE_UNMASKED, 5'd1, 8'h11, 32'd7, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, erlog_pkg::TYPE_ANY, 5'd31, 8'hFF, STAMP_MAX,
                 '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd1, 5'd0, 8'h00, 32'd9, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, TYPE_LAST_MASKED, 5'd2, 8'h33, 32'd11, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd1, 5'd1, 8'h00, 32'd0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd4, 5'd3, 8'hFF, STAMP_MAX, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd1, 5'd28, 8'h5A, 32'h8000_0000, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd7, 5'd10, 8'hA5, 32'd100, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd8, 5'd9, 8'h3C, 32'd50, '0, '0));
    // newest first on an open filter
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd0, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd0, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd0, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    // type filter with a full-range window, then a window that catches nothing
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd1, 4'd4, 5'd0, 8'd0, '0, 32'd1, STAMP_MAX));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd1, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd2, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, 32'd200,
                 32'd300));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd2, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    // end and resume keep the read position
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd3, 4'd1, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_END, 3'd3, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_RESUME, 3'd3, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd3, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_WRITE, 3'd0, 4'd5, 5'd5, 8'h77, 32'd150, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd3, 4'd0, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(CMD_SPARE_LO, 3'd5, 4'd9, 5'd17, 8'h81, 32'h1234_5678, '1, '1));
    queue_cmd(mk(CMD_SPARE_HI, 3'd7, 4'd1, 5'd1, 8'hFF, STAMP_MAX, '1, '1));
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd7, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, STAMP_MAX,
                 '0));
    queue_cmd(mk(erlog_pkg::CMD_READ, 3'd7, 4'd0, 5'd0, 8'd0, '0, '0, '0));

    random_phase(900);

    // a write-heavy stretch with sessions open, so their remaining counts keep
    // growing while reads dig into them
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd4, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd5, 4'd1, 5'd0, 8'd0, '0, '0, '0));
    queue_cmd(mk(erlog_pkg::CMD_START, 3'd6, erlog_pkg::TYPE_ANY, 5'd0, 8'd0, '0, 32'd1,
                 32'd4000));
    repeat (FILL_ITEMS) begin
      c = noise_cmd();
      if ($urandom_range(0, 9) == 0) begin
        c.cmd = erlog_pkg::CMD_READ;
        c.session = 3'($urandom_range(4, 6));
      end else begin
        c.cmd = erlog_pkg::CMD_WRITE;
        do begin
          c.etype = 4'($urandom_range(1, TYPE_LAST_MASKED));
          c.esub = 5'($urandom_range(0, 31));
        end while (!KEEP_MASK[c.etype][c.esub]);
        c.etime = rand_stamp();
      end
      queue_cmd(c);
    end

    random_phase(520);

    third_mark = pending_q.size() / 3;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent: %0d events logged, %0d flagged live, %0d searches hit, %0d ran dry",
             accepted_n, kept_n, live_n, found_n, empty_n);
    $display("ring rolled over: %0d, write position now %0d, %0d mismatching results",
             ring_full, wr_pos, mismatches);
    if (mismatches == 0 && reply_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
